@@ rtl/first_match_pattern_search_macros.svh @@
// ----------------------------------------------------------------------------
// first_match_pattern_search assertion macros
// Assertion helpers for the pattern search block, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_PATTERN_SEARCH_MACROS_SVH
`define FIRST_MATCH_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FMPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define FMPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FMPS_ASSERT_NOW(label, clk, rst, ante, cons)
`define FMPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/fmps_pkg.sv @@
// ----------------------------------------------------------------------------
// fmps_pkg
// Shared constants and types of the first-match pattern search block.
// ----------------------------------------------------------------------------
package fmps_pkg;

   localparam int PATTERN_MAX  = 8;
   localparam int SEQUENCE_MAX = 256;

   localparam int SYMBOL_W  = 16;
   localparam int SLOT_W    = 3;
   localparam int CFG_W     = 4;
   localparam int POS_W     = 8;
   localparam int PAT_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
   localparam int SEEN_W    = $clog2(SEQUENCE_MAX + 1);

   localparam int REQ_DATA_W = 24;   // slot, symbol, zero fill
   localparam int RSP_DATA_W = 16;   // matched, position, zero fill

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SYMBOL = 1'b1
   } fmps_op_type;

   typedef struct packed {
      fmps_op_type               kind;
      logic [PAT_IDX_W-1:0]      idx;
      logic [SYMBOL_W-1:0]       symbol;
      logic                      last;
   } fmps_cmd_type;

endpackage

@@ rtl/fmps_front.sv @@
// ----------------------------------------------------------------------------
// fmps_front
// Accepts requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module fmps_front
   import fmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slot [2:0], symbol [18:3], zero fill
   input  logic                  req_tuser,   // op
   input  logic                  req_tlast,
   output logic                  head_valid,
   output fmps_cmd_type          head_cmd,
   input  logic                  head_pop
);

   fmps_cmd_type         entry_ff [QUEUE_DEPTH];
   fmps_cmd_type         cmd;
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]    slot;
   logic                 keep;
   logic                 push;
   logic                 pop;

   assign slot       = req_tdata[SLOT_W-1:0];
   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      cmd.kind   = fmps_op_type'(req_tuser);
      cmd.idx    = PAT_IDX_W'(slot);
      cmd.symbol = req_tdata[SLOT_W +: SYMBOL_W];
      cmd.last   = req_tlast & (cmd.kind == OP_SYMBOL);
      // loads to slots that do not exist are dropped here
      keep = (cmd.kind == OP_SYMBOL) || (int'(slot) < PATTERN_MAX);
   end

   assign push = req_tvalid && req_tready && keep;
   assign pop  = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   begin
            count_in = QCNT_W'(count_ff + 1'b1);
         end
         2'b01:   begin
            count_in = QCNT_W'(count_ff - 1'b1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ rtl/fmps_back.sv @@
// ----------------------------------------------------------------------------
// fmps_back
// Executes queued commands: pattern loads, window shift, compare, result.
// ----------------------------------------------------------------------------
module fmps_back
   import fmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   input  logic                  head_valid,
   input  fmps_cmd_type          head_cmd,
   output logic                  head_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // matched [0], position [8:1], zero fill
);

   logic [SYMBOL_W-1:0]   pattern_ff [PATTERN_MAX];
   logic [SYMBOL_W-1:0]   window_ff  [PATTERN_MAX];
   logic [SYMBOL_W-1:0]   window_in  [PATTERN_MAX];
   logic [SYMBOL_W-1:0]   shifted    [PATTERN_MAX];
   logic [CFG_W-1:0]      cfg_len_ff;
   logic [SEEN_W-1:0]     seen_ff, seen_in, seen_next;
   logic                  found_ff, found_in, found_a, found_b;
   logic [POS_W-1:0]      start_ff, start_in, start_a, start_b;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]      len_use;
   logic [LEN_W-1:0]      tap;
   logic                  out_free;
   logic                  take;
   logic                  sym_go;
   logic                  load_go;
   logic                  in_range;
   logic                  all_eq;
   logic                  hit;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign len_use  = LEN_W'((int'(cfg_len_ff) > PATTERN_MAX) ? PATTERN_MAX
                                                             : int'(cfg_len_ff));
   assign out_free = !rsp_valid_ff || rsp_tready;
   // a last symbol waits until the output register can take its result
   assign take     = head_valid &&
                     ((head_cmd.kind == OP_LOAD) || !head_cmd.last || out_free);
   assign head_pop = take;
   assign sym_go   = take && (head_cmd.kind == OP_SYMBOL);
   assign load_go  = take && (head_cmd.kind == OP_LOAD);
   assign in_range = (int'(seen_ff) < SEQUENCE_MAX);
   assign seen_next = SEEN_W'(seen_ff + 1'b1);

   always_comb begin
      shifted[0] = head_cmd.symbol;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         shifted[k] = window_ff[k-1];
      end
   end

   // pattern slot i lines up with window tap len-1-i
   always_comb begin
      all_eq = 1'b1;
      tap    = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         tap = LEN_W'(len_use - LEN_W'(1) - LEN_W'(i));
         if (LEN_W'(i) < len_use) begin
            if (pattern_ff[i] != shifted[tap[PAT_IDX_W-1:0]]) begin
               all_eq = 1'b0;
            end
         end
      end
   end

   always_comb begin
      // empty pattern matches at the start
      found_a = found_ff || (len_use == '0);
      start_a = found_ff ? start_ff : '0;
      hit     = in_range && !found_a && (int'(seen_next) >= int'(len_use)) && all_eq;
      found_b = found_a || hit;
      start_b = hit ? POS_W'(seen_next - SEEN_W'(len_use)) : start_a;
   end

   always_comb begin
      window_in    = window_ff;
      seen_in      = seen_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (sym_go) begin
         if (head_cmd.last) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
               window_in[k] = '0;
            end
            seen_in      = '0;
            found_in     = 1'b0;
            start_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = RSP_DATA_W'({(found_b ? start_b : POS_W'(0)), found_b});
         end else begin
            if (in_range) begin
               window_in = shifted;
               seen_in   = seen_next;
            end
            found_in = found_b;
            start_in = start_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            window_ff[k] <= '0;
         end
         cfg_len_ff   <= '0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         cfg_len_ff   <= csr_wr_en ? csr_wr_data : cfg_len_ff;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load_go) begin
         pattern_ff[head_cmd.idx] <= head_cmd.symbol;
      end
   end

endmodule

@@ rtl/first_match_pattern_search.sv @@
// ----------------------------------------------------------------------------
// first_match_pattern_search
// Streams a symbol sequence against a loaded pattern and reports the first hit.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: req_tuser low loads symbol into pattern slot,
// req_tuser high presents a sequence symbol, req_tlast marks the sequence end.
// csr_wr_en/csr_wr_data write the pattern length (values above 8 act as 8);
// write it only while no request is in flight.
// One response per sequence leaves on rsp_*: matched flag and start position
// of the earliest match (position 0 when there is no match).
// Throughput: one request per cycle while no held response stalls a last
// symbol. A two-entry command queue sits between the request decoder and the
// execution stage, which shifts the window and compares all slots combinationally.
// With the queue empty the last symbol passes through the command queue and
// then the response register. While rsp_tready is low the finished response
// is held and the next sequence keeps streaming until its own last symbol
// reaches the execution stage; then the queue fills and req_tready drops.
// Reset clears the length, window and sequence state and empties the queue;
// pattern slots are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "first_match_pattern_search_macros.svh"

module first_match_pattern_search
   import fmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slot [2:0], symbol [18:3], zero fill
   input  logic                  req_tuser,   // op
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // matched [0], position [8:1], zero fill
);

   logic         head_valid;
   fmps_cmd_type head_cmd;
   logic         head_pop;
   logic         last_pop;

   fmps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   fmps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .head_pop    (head_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // a sequence end leaves the queue this cycle
   assign last_pop = head_pop && (head_cmd.kind == OP_SYMBOL) && head_cmd.last;

   // commands leave the queue only when one is there
   `FMPS_ASSERT_NOW(a_pop_needs_head, clock, reset, head_pop, head_valid)
   // a held response blocks the next sequence end
   `FMPS_ASSERT_NOW(a_stall_blocks_last, clock, reset, rsp_tvalid && !rsp_tready, !last_pop)
   // a response only follows a sequence end taken from the queue
   `FMPS_ASSERT_NOW(a_rsp_from_last, clock, reset, $rose(rsp_tvalid), $past(last_pop))

endmodule
